// ----- sv/imk_pkg.sv -----
package imk_pkg;

    // Defaults and fixed widths
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int PERIOD_W        = 16;
    localparam int UNITS_W         = 2;
    localparam int DVS_W           = 10;
    localparam int LV_W            = 5;

    // Speed conversion: period = PERIOD_NUM / (WPM_SCALE * sample / WPM_DIV + WPM_BASE)
    localparam int PERIOD_RESET = 3932;
    localparam int WPM_SCALE    = 25;
    localparam int WPM_DIV      = 888;
    localparam int WPM_BASE     = 3;
    localparam int PERIOD_NUM   = 39322;

    // Divide by 888 = 8 * 111: drop 3 bits, then multiply by ceil(2**21 / 111)
    // and keep bits 21 and up. Exact while the shifted value stays below 2**14,
    // which covers 12-bit samples.
    localparam int WPM_PRE_SH   = 3;
    localparam int WPM_RECIP    = 18894;
    localparam int WPM_RECIP_SH = 21;
    localparam int WPM_PROD_W   = 32;

    // Bit positions of the output levels
    localparam int LV_MUTE  = 0;
    localparam int LV_SHAPE = 1;
    localparam int LV_TR    = 2;
    localparam int LV_KEY   = 3;
    localparam int LV_TONE  = 4;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_DIT  = 3'd1,
        PH_DAH  = 3'd2,
        PH_REST = 3'd3,
        PH_TUNE = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_EVAL   = 3'd1,
        ST_SCALE  = 3'd2,
        ST_DIV    = 3'd3,
        ST_COMMIT = 3'd4
    } t_ctrl_state;

    typedef struct packed {
        logic capture;
        logic div_start;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic need_speed;
        logic div_done;
    } t_sts;

endpackage

// ----- sv/imk_div.sv -----
module imk_div #(
    parameter int DW = 16,
    parameter int VW = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [VW:0] trial;
    logic [VW:0] diff;
    logic        fits;

    // One quotient bit per cycle, restoring
    always_comb begin
        trial = {r_rem, r_quo[DW-1]};
        fits  = (trial >= {1'b0, r_dvs});
        diff  = trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], fits};
            r_rem <= fits ? diff[VW-1:0] : trial[VW-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

`ifndef SYNTHESIS
    a_last_step_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start && r_cnt == CW'(1)) |=> (o_done && !r_busy))
        else $error("divider did not finish after its last step");
`endif

endmodule

// ----- sv/imk_ctrl.sv -----
module imk_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output imk_pkg::t_cmd o_cmd,
    input  imk_pkg::t_sts i_sts
);
    import imk_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;
    logic        r_out_valid;
    logic        out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (i_sts.need_speed) begin
                    n_state = ST_SCALE;
                end else begin
                    n_state = ST_COMMIT;
                end
            end
            ST_SCALE: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_no_commit_over_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !o_cmd.commit)
        else $error("result overwritten while stalled");
    a_accept_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == ST_EVAL))
        else $error("accepted transaction not evaluated");
`endif

endmodule

// ----- sv/imk_dp.sv -----
module imk_dp #(
    parameter int SAMPLE_BITS = imk_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  imk_pkg::t_cmd          i_cmd,
    output imk_pkg::t_sts          o_sts,
    input  logic                   i_dit_pressed,
    input  logic                   i_dah_pressed,
    input  logic                   i_tune_pressed,
    input  logic [SAMPLE_BITS-1:0] i_speed_sample,
    output logic [imk_pkg::LV_W-1:0] o_levels
);
    import imk_pkg::*;

    localparam int ScaledW = SAMPLE_BITS + 5;

    logic                   r_dit;
    logic                   r_dah;
    logic                   r_tune;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [DVS_W-1:0]       r_wpm;

    t_phase               r_phase, n_phase;
    logic                 r_last, n_last;
    logic [PERIOD_W-1:0]  r_tick, n_tick;
    logic [UNITS_W-1:0]   r_units, n_units;
    logic [PERIOD_W-1:0]  r_period, n_period;
    logic [LV_W-1:0]      r_lv, n_lv;

    logic [ScaledW-1:0]    wpm_scaled;
    logic [WPM_PROD_W-1:0] wpm_prod;
    logic [DVS_W-1:0]      wpm_next;
    logic [PERIOD_W-1:0]   div_quo;
    logic                  div_done;

    logic [PERIOD_W-1:0] tick_inc;
    logic [PERIOD_W-1:0] tick_adv;
    logic                unit_done;
    logic [UNITS_W-1:0]  units_inc;
    logic [UNITS_W-1:0]  units_need;
    logic                phase_idle;

    // Hold the captured tick while it is worked on
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_dit    <= i_dit_pressed;
            r_dah    <= i_dah_pressed;
            r_tune   <= i_tune_pressed;
            r_sample <= i_speed_sample;
        end
    end

    // wpm = 25 * sample / 888 + 3, by reciprocal multiply; registered
    // before it feeds the divider
    always_comb begin
        wpm_scaled = ScaledW'(r_sample) * ScaledW'(WPM_SCALE);
        wpm_prod   = WPM_PROD_W'(wpm_scaled[ScaledW-1:WPM_PRE_SH]) *
                     WPM_PROD_W'(WPM_RECIP);
        wpm_next   = wpm_prod[WPM_RECIP_SH +: DVS_W] + DVS_W'(WPM_BASE);
    end

    always_ff @(posedge i_clk) begin
        r_wpm <= wpm_next;
    end

    // Unit period = 39322 / wpm
    imk_div #(
        .DW (PERIOD_W),
        .VW (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (PERIOD_W'(PERIOD_NUM)),
        .i_divisor  (r_wpm),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign phase_idle = !(r_phase == PH_DIT || r_phase == PH_DAH ||
                          r_phase == PH_REST || r_phase == PH_TUNE);

    always_comb begin
        o_sts.need_speed = phase_idle && !r_dit && !r_dah && !r_tune;
        o_sts.div_done   = div_done;
    end

    always_comb begin
        tick_inc   = r_tick + 1'b1;
        unit_done  = (tick_inc >= r_period);
        tick_adv   = unit_done ? '0 : tick_inc;
        units_inc  = r_units + 1'b1;
        units_need = (r_phase == PH_DAH) ? UNITS_W'(3) : UNITS_W'(1);
    end

    always_comb begin
        n_phase  = r_phase;
        n_last   = r_last;
        n_tick   = r_tick;
        n_units  = r_units;
        n_period = r_period;
        n_lv     = r_lv;
        if (i_cmd.commit) begin
            unique case (r_phase)
                PH_DIT, PH_DAH: begin
                    n_tick = tick_adv;
                    if (unit_done) begin
                        n_units = units_inc;
                        if (units_inc >= units_need) begin
                            n_last                = (r_phase == PH_DAH);
                            n_lv[LV_SHAPE]        = 1'b0;
                            n_lv[LV_KEY]          = 1'b0;
                            n_lv[LV_TONE]         = 1'b0;
                            n_units               = '0;
                            n_phase               = PH_REST;
                        end
                    end
                end
                PH_REST: begin
                    n_tick = tick_adv;
                    if (unit_done) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_TUNE: begin
                    n_tick = tick_adv;
                    if (!r_tune) begin
                        n_lv[LV_MUTE]  = 1'b0;
                        n_lv[LV_SHAPE] = 1'b0;
                        n_lv[LV_TR]    = 1'b0;
                        n_lv[LV_TONE]  = 1'b0;
                        n_phase        = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    if (r_dit || r_dah) begin
                        if (r_dit && r_dah) begin
                            n_phase = r_last ? PH_DIT : PH_DAH;
                        end else if (r_dit) begin
                            n_phase = PH_DIT;
                        end else begin
                            n_phase = PH_DAH;
                        end
                        n_tick  = '0;
                        n_units = '0;
                        n_lv    = '1;
                    end else if (r_tune) begin
                        n_tick         = tick_adv;
                        n_lv[LV_MUTE]  = 1'b1;
                        n_lv[LV_SHAPE] = 1'b1;
                        n_lv[LV_TR]    = 1'b1;
                        n_lv[LV_TONE]  = 1'b1;
                        n_phase        = PH_TUNE;
                    end else begin
                        n_lv[LV_MUTE] = 1'b0;
                        n_lv[LV_TR]   = 1'b0;
                        n_period      = div_quo;
                        n_tick        = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_last   <= 1'b0;
            r_tick   <= '0;
            r_units  <= '0;
            r_period <= PERIOD_W'(PERIOD_RESET);
            r_lv     <= '0;
        end else begin
            r_phase  <= n_phase;
            r_last   <= n_last;
            r_tick   <= n_tick;
            r_units  <= n_units;
            r_period <= n_period;
            r_lv     <= n_lv;
        end
    end

    assign o_levels = r_lv;

`ifndef SYNTHESIS
    a_tick_in_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_period != '0) && (r_tick < r_period))
        else $error("tick count outside unit period");
    a_key_implies_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lv[LV_KEY] |-> (r_lv[LV_MUTE] && r_lv[LV_TR]))
        else $error("key raised without mute and T/R");
`endif

endmodule

// ----- sv/iambic_morse_keyer_core.sv -----
// Iambic Morse keyer core, one input transaction per timer tick.
//
// Input channel (i_in_valid / o_in_stall): paddle levels, tune button and the
// speed potentiometer sample for one tick. Output channel (o_out_valid /
// i_out_stall): the five line levels after that tick, one result per tick.
//
// Each accepted tick passes through the EVAL and COMMIT states, and its result
// is registered on leaving COMMIT; no new tick is taken until the block is back
// in IDLE. An idle tick with nothing pressed also recomputes the unit period:
// the sample is scaled to words per minute by a reciprocal multiply and
// registered, then in SCALE and DIV a bit-serial divider forms 39322 / wpm
// before COMMIT. This divider path sets the worst case rate.
//
// A finished result sits in the output register while the next tick is
// accepted and worked on; the new result is written only once the old one
// has been taken, so a stalled receiver holds the block in its final step.
//
// Reset (synchronous, active low): keyer idle, last element dit, counters
// cleared, unit period 3932 ticks, all outputs low, no result pending.
module iambic_morse_keyer_core #(
    parameter int SAMPLE_BITS = imk_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_dit_pressed,
    input  logic                   i_dah_pressed,
    input  logic                   i_tune_pressed,
    input  logic [SAMPLE_BITS-1:0] i_speed_sample,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_mute_on,
    output logic                   o_shape_on,
    output logic                   o_tr_switch_on,
    output logic                   o_key_on,
    output logic                   o_sidetone_on
);
    import imk_pkg::*;

    t_cmd            cmd;
    t_sts            sts;
    logic [LV_W-1:0] levels;

    // Sequence capture, speed scaling, divide and commit
    imk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // Keyer state, unit timing, speed divider and output levels
    imk_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_dit_pressed  (i_dit_pressed),
        .i_dah_pressed  (i_dah_pressed),
        .i_tune_pressed (i_tune_pressed),
        .i_speed_sample (i_speed_sample),
        .o_levels       (levels)
    );

    // Level register doubles as the output register
    assign o_mute_on      = levels[LV_MUTE];
    assign o_shape_on     = levels[LV_SHAPE];
    assign o_tr_switch_on = levels[LV_TR];
    assign o_key_on       = levels[LV_KEY];
    assign o_sidetone_on  = levels[LV_TONE];

endmodule

// ----- bench/tb_iambic_morse_keyer_core.sv -----
module tb_iambic_morse_keyer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import imk_pkg::*;

    localparam int SAMPLE_BITS     = SAMPLE_BITS_DEF;
    localparam int IDLE_PCT        = 35;    // chance of an idle cycle on either side
    localparam int QUIET_FROM      = 300;   // window (in transactions) with no idling
    localparam int QUIET_TO        = 450;
    localparam int HOLD_AT         = 150;   // results taken before the long receiver hold
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_MAX    = 3000;  // cycles with no transaction on either side
    localparam int DRAIN_CYCLES    = 60;    // about one full speed update and then some
    localparam int FAST_SAMPLE_MIN = 880;   // samples above this give the shortest units
    localparam int TUNE_PCT        = 40;
    localparam int CHATTER_TICKS   = 380;
    localparam int RIDE_TICKS      = 300;   // ticks into an element, short of one unit

    typedef enum int {
        EL_DIT,
        EL_DAH,
        EL_BOTH
    } t_element_kind;

    // Tracks the keyer state tick by tick and queues the line levels each
    // accepted tick should produce.
    class keyer_levels_board;
        t_phase              phase;
        logic                last_dah;
        logic [PERIOD_W-1:0] ticks;
        logic [UNITS_W-1:0]  units;
        logic [PERIOD_W-1:0] period;
        logic [LV_W-1:0]     levels;
        logic [LV_W-1:0]     expected_levels[$];
        int                  mismatches;
        int                  levels_checked;

        function new();
            phase          = PH_IDLE;
            last_dah       = 1'b0;
            ticks          = '0;
            units          = '0;
            period         = PERIOD_W'(PERIOD_RESET);
            levels         = '0;
            mismatches     = 0;
            levels_checked = 0;
        endfunction

        // Count one tick into the current unit; true when the unit wraps.
        function bit unit_done();
            ticks = ticks + 1'b1;
            if (ticks >= period) begin
                ticks = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function logic [PERIOD_W-1:0] period_for_sample(logic [SAMPLE_BITS-1:0] sample);
            int unsigned wpm;
            wpm = (WPM_SCALE * int'(sample)) / WPM_DIV + WPM_BASE;
            return PERIOD_W'(PERIOD_NUM / wpm);
        endfunction

        function void start_element(t_phase ph);
            phase  = ph;
            ticks  = '0;
            units  = '0;
            levels = '1;
        endfunction

        function void note_tick(logic dit, logic dah, logic tune,
                                logic [SAMPLE_BITS-1:0] sample);
            case (phase)
                PH_DIT, PH_DAH: begin
                    if (unit_done()) begin
                        units = units + 1'b1;
                        if (units >= ((phase == PH_DAH) ? 2'd3 : 2'd1)) begin
                            last_dah         = (phase == PH_DAH);
                            levels[LV_SHAPE] = 1'b0;
                            levels[LV_KEY]   = 1'b0;
                            levels[LV_TONE]  = 1'b0;
                            units            = '0;
                            phase            = PH_REST;
                        end
                    end
                end
                PH_REST: begin
                    if (unit_done()) begin
                        phase = PH_IDLE;
                    end
                end
                PH_TUNE: begin
                    void'(unit_done());
                    if (!tune) begin
                        levels[LV_MUTE]  = 1'b0;
                        levels[LV_SHAPE] = 1'b0;
                        levels[LV_TR]    = 1'b0;
                        levels[LV_TONE]  = 1'b0;
                        phase            = PH_IDLE;
                    end
                end
                default: begin
                    phase = PH_IDLE;
                    if (dit && dah) begin
                        start_element(last_dah ? PH_DIT : PH_DAH);
                    end else if (dit) begin
                        start_element(PH_DIT);
                    end else if (dah) begin
                        start_element(PH_DAH);
                    end else if (tune) begin
                        void'(unit_done());
                        levels[LV_MUTE]  = 1'b1;
                        levels[LV_SHAPE] = 1'b1;
                        levels[LV_TR]    = 1'b1;
                        levels[LV_TONE]  = 1'b1;
                        phase            = PH_TUNE;
                    end else begin
                        levels[LV_MUTE] = 1'b0;
                        levels[LV_TR]   = 1'b0;
                        period          = period_for_sample(sample);
                        ticks           = '0;
                    end
                end
            endcase
            expected_levels.push_back(levels);
        endfunction

        function void compare_bit(string field, logic want, logic got);
            if (got !== want) begin
                $error("%s: expected %0b, got %0b", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_levels(logic mute, logic shape, logic tr, logic key, logic tone);
            logic [LV_W-1:0] want;
            if (expected_levels.size() == 0) begin
                $error("result transaction with no tick outstanding");
                mismatches++;
                return;
            end
            want = expected_levels.pop_front();
            levels_checked++;
            compare_bit("mute_on", want[LV_MUTE], mute);
            compare_bit("shape_on", want[LV_SHAPE], shape);
            compare_bit("tr_switch_on", want[LV_TR], tr);
            compare_bit("key_on", want[LV_KEY], key);
            compare_bit("sidetone_on", want[LV_TONE], tone);
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic                   i_dit_pressed;
    logic                   i_dah_pressed;
    logic                   i_tune_pressed;
    logic [SAMPLE_BITS-1:0] i_speed_sample;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic                   o_mute_on;
    logic                   o_shape_on;
    logic                   o_tr_switch_on;
    logic                   o_key_on;
    logic                   o_sidetone_on;

    keyer_levels_board sb = new();
    int                ticks_sent = 0;

    iambic_morse_keyer_core #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_dit_pressed (i_dit_pressed),
        .i_dah_pressed (i_dah_pressed),
        .i_tune_pressed(i_tune_pressed),
        .i_speed_sample(i_speed_sample),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_mute_on     (o_mute_on),
        .o_shape_on    (o_shape_on),
        .o_tr_switch_on(o_tr_switch_on),
        .o_key_on      (o_key_on),
        .o_sidetone_on (o_sidetone_on)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offer one tick and hold it until the block takes it. Called at a falling
    // edge and returns at the falling edge after the transaction, so valid is
    // assigned at most once per time step.
    task automatic send_tick(logic dit, logic dah, logic tune,
                             logic [SAMPLE_BITS-1:0] sample);
        // Insert a random gap, except inside the quiet window.
        if (!(ticks_sent >= QUIET_FROM && ticks_sent < QUIET_TO) &&
            $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
        i_in_valid     <= 1'b1;
        i_dit_pressed  <= dit;
        i_dah_pressed  <= dah;
        i_tune_pressed <= tune;
        i_speed_sample <= sample;
        // Hold the payload until a rising edge sees stall low.
        do @(posedge i_clk); while (o_in_stall);
        sb.note_tick(dit, dah, tune, sample);
        ticks_sent++;
        @(negedge i_clk);
    endtask

    // Drive random ticks until the keyer is back in idle: finish any element
    // and its rest, and drop tune if it is held. The paddles are ignored on
    // all of these ticks.
    task automatic settle();
        while (sb.phase != PH_IDLE) begin
            send_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
                      (sb.phase == PH_TUNE) ? 1'b0 : 1'($urandom_range(1)),
                      SAMPLE_BITS'($urandom));
        end
    endtask

    // Idle traffic: speed updates and tune on and off. Paddles stay open in
    // idle so no element starts; while tuning they toggle at random.
    task automatic chatter(int n);
        logic tune;
        repeat (n) begin
            tune = ($urandom_range(99) < TUNE_PCT);
            if (sb.phase == PH_TUNE) begin
                send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), tune,
                          SAMPLE_BITS'($urandom));
            end else begin
                send_tick(1'b0, 1'b0, tune, SAMPLE_BITS'($urandom));
            end
        end
    endtask

    // Start one element at a fast speed, then keep sending random ticks into
    // it; a unit is far longer than the run, so the element stays keyed.
    task automatic play_element(t_element_kind kind, int n);
        logic tune;
        tune = 1'($urandom_range(1));
        settle();
        send_tick(1'b0, 1'b0, 1'b0,
                  SAMPLE_BITS'($urandom_range(2**SAMPLE_BITS - 1, FAST_SAMPLE_MIN)));
        case (kind)
            EL_DIT:  send_tick(1'b1, 1'b0, tune, SAMPLE_BITS'($urandom));
            EL_DAH:  send_tick(1'b0, 1'b1, tune, SAMPLE_BITS'($urandom));
            default: send_tick(1'b1, 1'b1, tune, SAMPLE_BITS'($urandom));
        endcase
        repeat (n) begin
            send_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
                      1'($urandom_range(1)), SAMPLE_BITS'($urandom));
        end
    endtask

    // Result side: stall at random, drop stalls in the quiet window, and once
    // hold off for a long stretch so the block backs up into its input.
    initial begin : result_sink
        bit held;
        held        = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && sb.levels_checked >= HOLD_AT) begin
                held = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (sb.levels_checked >= QUIET_FROM && sb.levels_checked < QUIET_TO) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Take each result transaction at the rising edge and check it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_levels(o_mute_on, o_shape_on, o_tr_switch_on, o_key_on, o_sidetone_on);
        end
    end

    // Abort when neither side completes a transaction for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_MAX) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_dit_pressed  = 1'b0;
        i_dah_pressed  = 1'b0;
        i_tune_pressed = 1'b0;
        i_speed_sample = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part.
        send_tick(1'b0, 1'b0, 1'b0, '0);              // slowest speed, lines stay low
        send_tick(1'b0, 1'b0, 1'b0, SAMPLE_BITS'('h2AA));
        send_tick(1'b0, 1'b0, 1'b0, SAMPLE_BITS'('h155));
        send_tick(1'b0, 1'b0, 1'b1, '1);              // enter tune: no key line
        send_tick(1'b1, 1'b1, 1'b1, '0);              // paddles ignored while tuning
        send_tick(1'b0, 1'b1, 1'b0, '1);              // release tune, dah on same tick ignored
        send_tick(1'b0, 1'b0, 1'b1, SAMPLE_BITS'('h155));
        send_tick(1'b0, 1'b0, 1'b0, SAMPLE_BITS'('h2AA)); // release tune, nothing pressed
        send_tick(1'b0, 1'b0, 1'b0, '1);              // fastest speed

        // Random part: idle traffic, then one element held to the end.
        chatter(CHATTER_TICKS);
        play_element(t_element_kind'($urandom_range(2)), RIDE_TICKS);

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
